### rtl/mre_pkg.sv
`default_nettype none

package mre_pkg;

    localparam int QUEUE_DEPTH  = 256;
    localparam int BUTTON_COUNT = 16;

    // buttons field is 16 bits wide, so at most 16 buttons are seen
    localparam int BTN_USED   = (BUTTON_COUNT < 16) ? BUTTON_COUNT : 16;
    localparam int BTN_IDX_W  = (BTN_USED > 1) ? $clog2(BTN_USED) : 1;
    localparam int BUDGET_MAX = QUEUE_DEPTH - 1;
    localparam int AXES       = 4;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_OPEN   = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;

    localparam logic [3:0] KIND_DELTA = 4'd0;
    localparam logic [3:0] KIND_ABS   = 4'd4;
    localparam logic [3:0] KIND_DOWN  = 4'd8;
    localparam logic [3:0] KIND_UP    = 4'd9;
    localparam logic [3:0] KIND_SYNC  = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_AXIS,
        ST_BUTTON,
        ST_SYNC
    } t_state;

    typedef struct packed {
        logic do_open;
        logic do_close;
        logic load;
        logic accum;
        logic axis_emit;
        logic axis_next;
        logic btn_emit;
        logic sync_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic       is_open;
        logic [1:0] req_op;
        logic       budget_zero;
        logic       axis_pending;
        logic       axis_final;
        logic       btn_pending;
        logic       out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/mre_req_if.sv
`default_nettype none

interface mre_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  operation;
    logic        [15:0] buttons;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic signed [31:0] w_value;
    logic        [3:0]  absolute_mask;
    logic        [7:0]  free_slots;

    modport source (
        output valid, operation, buttons, x_value, y_value, z_value, w_value,
               absolute_mask, free_slots,
        input  ready
    );
    modport sink (
        input  valid, operation, buttons, x_value, y_value, z_value, w_value,
               absolute_mask, free_slots,
        output ready
    );
endinterface

`default_nettype wire

### rtl/mre_evt_if.sv
`default_nettype none

interface mre_evt_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  event_kind;
    logic signed [31:0] event_value;
    logic               last;

    modport source (
        output valid, event_kind, event_value, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_value, last,
        output ready
    );
endinterface

`default_nettype wire

### rtl/mre_ctrl.sv
`default_nettype none

module mre_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_req_valid,
    input  mre_pkg::t_dp_sts i_sts,
    output logic             o_req_ready,
    output mre_pkg::t_dp_cmd o_cmd
);
    import mre_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_sts.req_op == OP_OPEN) begin
                        o_cmd.do_open = 1'b1;
                    end else if (i_sts.req_op == OP_CLOSE) begin
                        o_cmd.do_close = 1'b1;
                    end else if (i_sts.req_op == OP_REPORT && i_sts.is_open) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_ACCUM;
                    end
                end
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = ST_AXIS;
            end
            ST_AXIS: begin
                if (i_sts.axis_pending) begin
                    // budget gone: stop, leave the rest pending
                    if (i_sts.budget_zero) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.axis_emit = 1'b1;
                        if (i_sts.axis_final) begin
                            n_state = ST_BUTTON;
                        end
                    end
                end else begin
                    o_cmd.axis_next = 1'b1;
                    if (i_sts.axis_final) begin
                        n_state = ST_BUTTON;
                    end
                end
            end
            ST_BUTTON: begin
                if (i_sts.btn_pending) begin
                    if (i_sts.budget_zero) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.btn_emit = 1'b1;
                    end
                end else begin
                    n_state = ST_SYNC;
                end
            end
            ST_SYNC: begin
                if (i_sts.budget_zero) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.sync_emit = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/mre_datapath.sv
`default_nettype none

module mre_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  mre_pkg::t_dp_cmd i_cmd,
    mre_req_if.sink          i_req,
    mre_evt_if.source        o_evt,
    output mre_pkg::t_dp_sts o_sts
);
    import mre_pkg::*;

    // architectural state
    logic                r_is_open;
    logic [31:0]         r_acc      [AXES];
    logic [31:0]         r_last_abs [AXES];
    logic [BTN_USED-1:0] r_rep_btn;

    // captured report
    logic [31:0]         r_val [AXES];
    logic [AXES-1:0]     r_amask;
    logic [BTN_USED-1:0] r_btn;
    logic [7:0]          r_budget;
    logic [1:0]          r_axis;

    // output register
    logic                r_out_valid;
    logic [3:0]          r_ev_kind;
    logic [31:0]         r_ev_value;
    logic                r_ev_last;

    logic                w_abs;
    logic                w_axis_pending;
    logic [BTN_USED-1:0] w_diff;
    logic [BTN_USED-1:0] w_low_bit;
    logic [BTN_IDX_W-1:0] w_btn_idx;
    logic                w_emit;
    logic [3:0]          n_ev_kind;
    logic [31:0]         n_ev_value;
    logic [7:0]          w_budget_in;

    assign w_abs          = r_amask[r_axis];
    assign w_axis_pending = w_abs ? (r_last_abs[r_axis] != r_val[r_axis])
                                  : (r_acc[r_axis] != 32'd0);

    assign w_diff    = r_btn ^ r_rep_btn;
    assign w_low_bit = w_diff & (~w_diff + 1'b1);

    always_comb begin
        w_btn_idx = '0;
        for (int i = BTN_USED - 1; i >= 0; i--) begin
            if (w_diff[i]) begin
                w_btn_idx = BTN_IDX_W'(i);
            end
        end
    end

    assign w_budget_in = (int'(i_req.free_slots) > BUDGET_MAX) ? 8'(BUDGET_MAX)
                                                               : i_req.free_slots;

    assign w_emit = i_cmd.axis_emit | i_cmd.btn_emit | i_cmd.sync_emit;

    always_comb begin
        if (i_cmd.axis_emit) begin
            n_ev_kind  = (w_abs ? KIND_ABS : KIND_DELTA) | {2'b00, r_axis};
            n_ev_value = w_abs ? r_val[r_axis] : r_acc[r_axis];
        end else if (i_cmd.btn_emit) begin
            n_ev_kind  = ((r_btn & w_low_bit) != '0) ? KIND_DOWN : KIND_UP;
            n_ev_value = 32'(w_btn_idx);
        end else begin
            n_ev_kind  = KIND_SYNC;
            n_ev_value = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_open   <= 1'b0;
            r_rep_btn   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_acc[i]      <= 32'd0;
                r_last_abs[i] <= INT_MAX;
            end
        end else begin
            if (i_cmd.do_open && !r_is_open) begin
                r_is_open <= 1'b1;
                for (int i = 0; i < AXES; i++) begin
                    r_last_abs[i] <= INT_MAX;
                end
            end
            if (i_cmd.do_close) begin
                r_is_open <= 1'b0;
            end
            if (i_cmd.accum) begin
                for (int i = 0; i < AXES; i++) begin
                    if (!r_amask[i]) begin
                        r_acc[i] <= r_acc[i] + r_val[i];
                    end
                end
            end
            if (i_cmd.axis_emit) begin
                if (w_abs) begin
                    r_last_abs[r_axis] <= r_val[r_axis];
                end else begin
                    r_acc[r_axis] <= 32'd0;
                end
            end
            if (i_cmd.btn_emit) begin
                r_rep_btn <= r_rep_btn ^ w_low_bit;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val[0] <= i_req.x_value;
            r_val[1] <= i_req.y_value;
            r_val[2] <= i_req.z_value;
            r_val[3] <= i_req.w_value;
            r_amask  <= i_req.absolute_mask;
            r_btn    <= i_req.buttons[BTN_USED-1:0];
            r_budget <= w_budget_in;
        end else if (w_emit) begin
            r_budget <= r_budget - 8'd1;
        end
        if (i_cmd.accum) begin
            r_axis <= 2'd0;
        end else if (i_cmd.axis_emit || i_cmd.axis_next) begin
            r_axis <= r_axis + 2'd1;
        end
        if (w_emit) begin
            r_ev_kind  <= n_ev_kind;
            r_ev_value <= n_ev_value;
            // sync always follows unless the budget ends here
            r_ev_last  <= i_cmd.sync_emit || (r_budget == 8'd1);
        end
    end

    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_kind  = r_ev_kind;
    assign o_evt.event_value = r_ev_value;
    assign o_evt.last        = r_ev_last;

    assign o_sts.is_open      = r_is_open;
    assign o_sts.req_op       = i_req.operation;
    assign o_sts.budget_zero  = (r_budget == 8'd0);
    assign o_sts.axis_pending = w_axis_pending;
    assign o_sts.axis_final   = (r_axis == 2'd3);
    assign o_sts.btn_pending  = (w_diff != '0);
    assign o_sts.out_free     = !r_out_valid || o_evt.ready;

endmodule

`default_nettype wire

### rtl/mouse_report_event_encoder.sv
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    operation, buttons, x/y/z/w_value, absolute_mask, free_slots
// o_evt     out  valid/ready    event_kind, event_value, last
//
// Open, close and dropped requests are handled in the idle state. A report is
// captured, then accumulated, then scanned over the four axes, then gives one
// button event per cycle while the output is free; then the button scan closes
// and sync is sent. The scan ends early once the free-slot budget runs out.
// Reset is synchronous and returns the block to closed with cleared sums and
// buttons. A stalled output holds the scan in place; the next request is taken
// while the final event waits.
module mouse_report_event_encoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mre_req_if.sink    i_req,
    mre_evt_if.source  o_evt
);
    import mre_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_req_ready;

    mre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    mre_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_evt   (o_evt),
        .o_sts   (w_sts)
    );

    assign i_req.ready = w_req_ready;

endmodule

`default_nettype wire
